// ===== rtl/set_assoc_lru_cache_sim_macros.svh =====
`ifndef SET_ASSOC_LRU_CACHE_SIM_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_SIM_MACROS_SVH
// Concurrent assertion on clk_i that is switched off while reset is applied.
`define SALC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Concurrent assertion on clk_i that also holds during reset.
`define SALC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`endif

// ===== rtl/salc_pkg.sv =====
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types, codes and helpers of the set-associative LRU cache simulator.
// ----------------------------------------------------------------------------
`default_nettype none

package salc_pkg;

  // Default geometry limits.
  localparam int unsigned MAX_SETS = 256;
  localparam int unsigned MAX_WAYS = 8;
  // Largest access in bytes; larger requests saturate to it.
  localparam int unsigned MAX_SIZE = 8;
  localparam logic [2:0]  MAX_BLOCK_BITS = 3'd6;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [3:0] SET_BITS_RST   = 4'd4;
  localparam logic [3:0] WAYS_RST       = 4'd1;
  localparam logic [2:0] BLOCK_BITS_RST = 3'd4;

  // Access opcodes.
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_STORE  = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // Lookup outcomes.
  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_MISS  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] address;
    logic [3:0]  access_size;
  } in_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic        last;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] eviction_total;
  } out_t;

  // One cache line as held in a set row.
  typedef struct packed {
    logic        valid;
    logic [31:0] tag;
    logic [31:0] stamp;
  } way_t;

  localparam way_t WAY_RESET = '{valid: 1'b0, tag: 32'hFFFF_FFFF, stamp: 32'd0};

  function automatic logic [31:0] sat_inc(input logic [31:0] x);
    sat_inc = (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/salc_mem.sv =====
// ----------------------------------------------------------------------------
// salc_mem
// Set memory: one row per set holding all ways, registered read, row valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module salc_mem #(
  parameter int unsigned MaxSets = salc_pkg::MAX_SETS,
  parameter int unsigned MaxWays = salc_pkg::MAX_WAYS,
  localparam int unsigned SetW   = (MaxSets > 1) ? $clog2(MaxSets) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          rd_en_i,
  input  wire logic [SetW-1:0]               rd_addr_i,
  output salc_pkg::way_t [MaxWays-1:0]       rd_row_o,
  input  wire logic                          wr_en_i,
  input  wire logic [SetW-1:0]               wr_addr_i,
  input  wire salc_pkg::way_t [MaxWays-1:0]  wr_row_i
);

  salc_pkg::way_t [MaxWays-1:0] mem_q [MaxSets];
  salc_pkg::way_t [MaxWays-1:0] rd_row_q;
  logic [MaxSets-1:0]           row_vld_q;
  logic                         rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_row_i;
    end
    if (rd_en_i) begin
      rd_row_q <= mem_q[rd_addr_i];
    end
  end

  // A row never written since reset reads back as reset lines.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= row_vld_q[rd_addr_i];
      end
    end
  end

  always_comb begin
    for (int w = 0; w < MaxWays; w++) begin
      rd_row_o[w] = rd_vld_q ? rd_row_q[w] : salc_pkg::WAY_RESET;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/salc_victim.sv =====
// ----------------------------------------------------------------------------
// salc_victim
// LRU victim search: a registered pairwise tree, one level per clock.
// ----------------------------------------------------------------------------
`default_nettype none

module salc_victim #(
  parameter int unsigned MaxWays = salc_pkg::MAX_WAYS,
  localparam int unsigned WayW   = (MaxWays > 1) ? $clog2(MaxWays) : 1,
  localparam int unsigned WcntW  = $clog2(MaxWays + 1)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         load_i,
  input  wire logic [MaxWays-1:0][31:0]     stamps_i,
  input  wire logic [WcntW-1:0]             nways_i,
  output logic [WayW-1:0]                   victim_o
);

  typedef struct packed {
    logic            vld;
    logic [31:0]     stamp;
    logic [WayW-1:0] idx;
  } cand_t;

  cand_t cand_q [MaxWays];
  cand_t red    [MaxWays];

  // The left candidate keeps its place on equal stamps, so the lowest way wins a tie.
  for (genvar i = 0; i < MaxWays; i++) begin : g_red
    if (2 * i + 1 < MaxWays) begin : g_pair
      assign red[i] = (cand_q[2*i+1].vld &&
                       (!cand_q[2*i].vld || cand_q[2*i+1].stamp < cand_q[2*i].stamp))
                      ? cand_q[2*i+1] : cand_q[2*i];
    end else if (2 * i < MaxWays) begin : g_single
      assign red[i] = cand_q[2*i];
    end else begin : g_none
      assign red[i] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxWays; i++) begin
        cand_q[i] <= '0;
      end
    end else if (load_i) begin
      for (int i = 0; i < MaxWays; i++) begin
        cand_q[i].vld   <= (WcntW'(i) < nways_i);
        cand_q[i].stamp <= stamps_i[i];
        cand_q[i].idx   <= WayW'(i);
      end
    end else begin
      for (int i = 0; i < MaxWays; i++) begin
        cand_q[i] <= red[i];
      end
    end
  end

  assign victim_o = cand_q[0].idx;

endmodule

`default_nettype wire

// ===== rtl/set_assoc_lru_cache_sim.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_sim: set-associative cache simulator with LRU replacement.
// Each block lookup steps through set read, evaluate and write back, with a
// pairwise victim search before the write back on an eviction; a new access is
// taken only in idle. Reset clears the row valid bits at once.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_lru_cache_sim #(
  parameter int unsigned MaxSets = salc_pkg::MAX_SETS,
  parameter int unsigned MaxWays = salc_pkg::MAX_WAYS
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [salc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [salc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire salc_pkg::in_t                      in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output salc_pkg::out_t                          out_data_o
);

  localparam int unsigned SetW  = (MaxSets > 1) ? $clog2(MaxSets) : 1;
  localparam int unsigned SbMax = $clog2(MaxSets + 1) - 1;
  localparam int unsigned WayW  = (MaxWays > 1) ? $clog2(MaxWays) : 1;
  localparam int unsigned WcntW = $clog2(MaxWays + 1);
  localparam int unsigned VLev  = (MaxWays > 1) ? $clog2(MaxWays) : 1;
  localparam int unsigned LevW  = $clog2(VLev + 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_EVAL  = 5'b00100,
    ST_VICT  = 5'b01000,
    ST_WRITE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Configuration.
  logic [3:0] set_bits_q, ways_q;
  logic [2:0] block_bits_q;

  // Per-transaction geometry and walk position.
  logic [3:0]       sb_q;
  logic [WcntW-1:0] nways_q;
  logic [31:0]      mask_q, blk0_q, blk_q;
  logic [3:0]       nlast_q, idx_q;
  logic             pass_q, two_pass_q;

  // Lookup results.
  logic             hit_q, inv_q;
  logic [WayW-1:0]  hit_way_q, inv_way_q;
  logic [LevW-1:0]  lev_q;

  logic [31:0] use_clk_q, hits_q, misses_q, evicts_q;
  logic [31:0] hits_d, misses_d, evicts_d;

  logic           out_valid_q;
  salc_pkg::out_t out_q;

  // Memory and victim unit.
  salc_pkg::way_t [MaxWays-1:0] rd_row, wr_row;
  logic [MaxWays-1:0][31:0]     stamps;
  logic [WayW-1:0]              victim;
  logic [SetW-1:0]              set_idx;
  logic [31:0]                  tag;

  // Accept-time decode.
  logic        in_acc;
  logic [3:0]  sb_eff, sz_raw, sz_eff;
  logic [WcntW-1:0] ways_eff;
  logic [2:0]  bb_eff;
  logic [5:0]  offset;
  logic [6:0]  span;

  logic            hit_any, inv_any;
  logic [WayW-1:0] hit_way, inv_way, sel_way;
  logic [1:0]      outcome;
  logic            is_last, go;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    sb_eff = (set_bits_q > 4'(SbMax)) ? 4'(SbMax) : set_bits_q;
    if (ways_q == 4'd0) begin
      ways_eff = WcntW'(1);
    end else if (32'(ways_q) > MaxWays) begin
      ways_eff = WcntW'(MaxWays);
    end else begin
      ways_eff = WcntW'(ways_q);
    end
    bb_eff = (block_bits_q > salc_pkg::MAX_BLOCK_BITS) ? salc_pkg::MAX_BLOCK_BITS
                                                       : block_bits_q;
    sz_raw = (in_data_i.access_size == 4'd0) ? 4'd1 : in_data_i.access_size;
    sz_eff = (32'(sz_raw) > salc_pkg::MAX_SIZE) ? 4'(salc_pkg::MAX_SIZE) : sz_raw;
    offset = 6'(in_data_i.address & ((32'd1 << bb_eff) - 32'd1));
    span   = 7'(offset) + 7'(sz_eff) - 7'd1;
  end

  assign set_idx = SetW'(blk_q & ~(32'hFFFF_FFFF << sb_q));
  assign tag     = blk_q >> sb_q;

  salc_mem #(
    .MaxSets (MaxSets),
    .MaxWays (MaxWays)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (state_q == ST_READ),
    .rd_addr_i (set_idx),
    .rd_row_o  (rd_row),
    .wr_en_i   ((state_q == ST_WRITE) && go),
    .wr_addr_i (set_idx),
    .wr_row_i  (wr_row)
  );

  always_comb begin
    for (int w = 0; w < MaxWays; w++) begin
      stamps[w] = rd_row[w].stamp;
    end
  end

  salc_victim #(
    .MaxWays (MaxWays)
  ) u_victim (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (state_q == ST_EVAL),
    .stamps_i (stamps),
    .nways_i  (nways_q),
    .victim_o (victim)
  );

  // First matching valid way and first invalid way among the ways in use.
  always_comb begin
    hit_any = 1'b0;
    hit_way = '0;
    inv_any = 1'b0;
    inv_way = '0;
    for (int w = MaxWays - 1; w >= 0; w--) begin
      if (WcntW'(w) < nways_q) begin
        if (rd_row[w].valid && rd_row[w].tag == tag) begin
          hit_any = 1'b1;
          hit_way = WayW'(w);
        end
        if (!rd_row[w].valid) begin
          inv_any = 1'b1;
          inv_way = WayW'(w);
        end
      end
    end
  end

  always_comb begin
    if (hit_q) begin
      sel_way = hit_way_q;
      outcome = salc_pkg::OUT_HIT;
    end else if (inv_q) begin
      sel_way = inv_way_q;
      outcome = salc_pkg::OUT_MISS;
    end else begin
      sel_way = victim;
      outcome = salc_pkg::OUT_EVICT;
    end
    wr_row                = rd_row;
    wr_row[sel_way].valid = 1'b1;
    wr_row[sel_way].tag   = tag;
    wr_row[sel_way].stamp = use_clk_q;
    hits_d   = hit_q ? salc_pkg::sat_inc(hits_q) : hits_q;
    misses_d = hit_q ? misses_q : salc_pkg::sat_inc(misses_q);
    evicts_d = (!hit_q && !inv_q) ? salc_pkg::sat_inc(evicts_q) : evicts_q;
  end

  assign is_last = (idx_q == nlast_q) && (pass_q == two_pass_q);
  assign go      = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && in_data_i.opcode != salc_pkg::OP_NONE) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_EVAL;
      ST_EVAL: state_d = (hit_any || inv_any) ? ST_WRITE : ST_VICT;
      ST_VICT: begin
        if (lev_q == LevW'(VLev - 1)) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (go) begin
          state_d = is_last ? ST_IDLE : ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      set_bits_q   <= salc_pkg::SET_BITS_RST;
      ways_q       <= salc_pkg::WAYS_RST;
      block_bits_q <= salc_pkg::BLOCK_BITS_RST;
      use_clk_q    <= '0;
      hits_q       <= '0;
      misses_q     <= '0;
      evicts_q     <= '0;
      out_valid_q  <= 1'b0;
      lev_q        <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          salc_pkg::CFG_SET_BITS:   set_bits_q   <= cfg_data_i;
          salc_pkg::CFG_WAYS:       ways_q       <= cfg_data_i;
          salc_pkg::CFG_BLOCK_BITS: block_bits_q <= cfg_data_i[2:0];
          default: ;
        endcase
      end
      if (state_q == ST_EVAL) begin
        use_clk_q <= use_clk_q + 32'd1;
        lev_q     <= '0;
      end
      if (state_q == ST_VICT) begin
        lev_q <= lev_q + LevW'(1);
      end
      if (state_q == ST_WRITE && go) begin
        hits_q      <= hits_d;
        misses_q    <= misses_d;
        evicts_q    <= evicts_d;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sb_q       <= sb_eff;
      nways_q    <= ways_eff;
      mask_q     <= 32'hFFFF_FFFF >> bb_eff;
      blk0_q     <= in_data_i.address >> bb_eff;
      blk_q      <= in_data_i.address >> bb_eff;
      nlast_q    <= 4'(span >> bb_eff);
      idx_q      <= 4'd0;
      pass_q     <= 1'b0;
      two_pass_q <= (in_data_i.opcode == salc_pkg::OP_MODIFY);
    end
    if (state_q == ST_EVAL) begin
      hit_q     <= hit_any;
      hit_way_q <= hit_way;
      inv_q     <= inv_any;
      inv_way_q <= inv_way;
    end
    if (state_q == ST_WRITE && go) begin
      out_q <= '{outcome: outcome, last: is_last, hit_total: hits_d,
                 miss_total: misses_d, eviction_total: evicts_d};
      // The second pass of a modify restarts at the first block.
      if (idx_q == nlast_q) begin
        idx_q  <= 4'd0;
        pass_q <= 1'b1;
        blk_q  <= blk0_q;
      end else begin
        idx_q <= idx_q + 4'd1;
        blk_q <= (blk_q + 32'd1) & mask_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/salc_checker.sv =====
// ----------------------------------------------------------------------------
// salc_checker
// Port-level checks of the cache simulator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "set_assoc_lru_cache_sim_macros.svh"

module salc_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_o,
  input wire salc_pkg::in_t  in_data_i,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire salc_pkg::out_t out_data_o
);

  logic in_skip, out_stall, out_hit, evict_ok;

  assign in_skip   = in_valid_i && in_ready_o && (in_data_i.opcode == salc_pkg::OP_NONE);
  assign out_stall = out_valid_o && !out_ready_i;
  assign out_hit   = out_valid_o && (out_data_o.outcome == salc_pkg::OUT_HIT);
  assign evict_ok  = (out_data_o.eviction_total <= out_data_o.miss_total);

  // The result flag is checked in the cycle after reset is seen, once reset has taken effect.
  `SALC_ASSERT_ALWAYS(a_rst_no_out, !rst_ni |=> !out_valid_o, "result valid during reset")

  `SALC_ASSERT(a_out_hold, out_stall |=> out_valid_o && $stable(out_data_o), "held result changed")

  `SALC_ASSERT(a_ignored_op, in_skip |=> in_ready_o, "ignored opcode started a transaction")

  `SALC_ASSERT(a_hit_count, out_hit |-> out_data_o.hit_total != 32'd0, "hit with zero hit total")

  `SALC_ASSERT(a_evict_le_miss, out_valid_o |-> evict_ok, "more evictions than misses")

endmodule

bind set_assoc_lru_cache_sim salc_checker u_salc_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the set-associative LRU cache simulator
// Memory accesses are sent over a valid/ready channel and every per-block lookup
// result is compared with a cycle-free model of the cache that tracks valid
// bits, tags, LRU stamps and the running hit, miss and eviction totals. The run
// steps through several cache geometries, out-of-range ones included, with
// random idle and stall patterns on both sides of the block.
// ----------------------------------------------------------------------------

module tb;
  import salc_pkg::*;

  localparam int unsigned LINES         = MAX_SETS * MAX_WAYS;
  localparam int unsigned DRAIN_CYCLES  = 150;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned RAND_PER_GEOM = 26;
  localparam int unsigned MAX_REPORTS   = 50;
  localparam int unsigned GEOMS         = 8;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SET_BITS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready_o;
  in_t                   in_data = '0;
  logic                  out_valid_o;
  logic                  out_ready = 1'b0;
  out_t                  out_data_o;

  set_assoc_lru_cache_sim dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Cache model state.
  logic        line_valid [LINES];
  logic [31:0] line_tag   [LINES];
  logic [31:0] line_stamp [LINES];
  logic [31:0] use_clock;
  logic [31:0] hit_cnt;
  logic [31:0] miss_cnt;
  logic [31:0] evict_cnt;
  logic [3:0]  geo_set_bits;
  logic [3:0]  geo_ways;
  logic [2:0]  geo_block_bits;

  in_t  pending_accesses [$];
  out_t expected_lookups [$];

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned error_count     = 0;
  int unsigned accesses_sent   = 0;
  int unsigned ignored_sent    = 0;
  int unsigned lookups_checked = 0;
  int unsigned quiet_cycles    = 0;
  logic [31:0] hot_addr [12];

  function automatic logic [31:0] sat_bump(input logic [31:0] x);
    return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
  endfunction

  function automatic int unsigned active_set_bits();
    int unsigned sb;
    sb = geo_set_bits;
    while (sb > 0 && (32'd1 << sb) > MAX_SETS) sb--;
    return sb;
  endfunction

  function automatic int unsigned active_ways();
    int unsigned w;
    w = geo_ways;
    if (w == 0) w = 1;
    if (w > MAX_WAYS) w = MAX_WAYS;
    return w;
  endfunction

  function automatic int unsigned active_block_bits();
    return (geo_block_bits > MAX_BLOCK_BITS) ? MAX_BLOCK_BITS : geo_block_bits;
  endfunction

  function automatic void clear_cache_model();
    for (int e = 0; e < LINES; e++) begin
      line_valid[e] = 1'b0;
      line_tag[e]   = 32'hFFFF_FFFF;
      line_stamp[e] = 32'd0;
    end
    use_clock      = '0;
    hit_cnt        = '0;
    miss_cnt       = '0;
    evict_cnt      = '0;
    geo_set_bits   = SET_BITS_RST;
    geo_ways       = WAYS_RST;
    geo_block_bits = BLOCK_BITS_RST;
  endfunction

  // Looks up one block in its set and updates valid, tag and LRU stamp.
  function automatic logic [1:0] lookup_block(input logic [31:0] tag,
                                              input int unsigned set_idx);
    int unsigned nw, base, victim;
    nw   = active_ways();
    base = (set_idx % MAX_SETS) * MAX_WAYS;
    use_clock = use_clock + 32'd1;
    for (int w = 0; w < nw; w++) begin
      if (line_valid[base + w] && line_tag[base + w] == tag) begin
        hit_cnt = sat_bump(hit_cnt);
        line_stamp[base + w] = use_clock;
        return OUT_HIT;
      end
    end
    miss_cnt = sat_bump(miss_cnt);
    for (int w = 0; w < nw; w++) begin
      if (!line_valid[base + w]) begin
        line_valid[base + w] = 1'b1;
        line_tag[base + w]   = tag;
        line_stamp[base + w] = use_clock;
        return OUT_MISS;
      end
    end
    // The oldest stamp loses; the lowest way wins a tie.
    victim = 0;
    for (int w = 1; w < nw; w++) begin
      if (line_stamp[base + w] < line_stamp[base + victim]) victim = w;
    end
    evict_cnt = sat_bump(evict_cnt);
    line_tag[base + victim]   = tag;
    line_stamp[base + victim] = use_clock;
    return OUT_EVICT;
  endfunction

  // Splits one access into the blocks it touches and queues one expected
  // lookup result per block and pass.
  function automatic void predict_access(input in_t req);
    int unsigned sb, bb, size, offset, blocks, passes;
    logic [63:0] blk, blk_mask, shifted;
    out_t        res;
    if (req.opcode == OP_NONE) return;
    sb   = active_set_bits();
    bb   = active_block_bits();
    size = req.access_size;
    if (size == 0) size = 1;
    if (size > MAX_SIZE) size = MAX_SIZE;
    offset   = req.address & ((32'd1 << bb) - 32'd1);
    blocks   = ((offset + size - 1) >> bb) + 1;
    passes   = (req.opcode == OP_MODIFY) ? 2 : 1;
    blk_mask = (64'd1 << (32 - bb)) - 64'd1;
    for (int p = 0; p < passes; p++) begin
      for (int i = 0; i < blocks; i++) begin
        blk     = ({32'd0, req.address >> bb} + i) & blk_mask;
        shifted = blk >> sb;
        res.outcome        = lookup_block(shifted[31:0],
                                          int'(blk & ((64'd1 << sb) - 64'd1)));
        res.last           = (p + 1 == passes) && (i + 1 == blocks);
        res.hit_total      = hit_cnt;
        res.miss_total     = miss_cnt;
        res.eviction_total = evict_cnt;
        expected_lookups.push_back(res);
      end
    end
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_lookup(input out_t got);
    out_t want;
    if (expected_lookups.size() == 0) begin
      report_error($sformatf("lookup result with none pending (outcome %0d)", got.outcome));
      return;
    end
    want = expected_lookups.pop_front();
    if (got.outcome !== want.outcome)
      report_error($sformatf("lookup %0d outcome got %0d want %0d",
                             lookups_checked, got.outcome, want.outcome));
    if (got.last !== want.last)
      report_error($sformatf("lookup %0d last got %0b want %0b",
                             lookups_checked, got.last, want.last));
    if (got.hit_total !== want.hit_total)
      report_error($sformatf("lookup %0d hit_total got %0d want %0d",
                             lookups_checked, got.hit_total, want.hit_total));
    if (got.miss_total !== want.miss_total)
      report_error($sformatf("lookup %0d miss_total got %0d want %0d",
                             lookups_checked, got.miss_total, want.miss_total));
    if (got.eviction_total !== want.eviction_total)
      report_error($sformatf("lookup %0d eviction_total got %0d want %0d",
                             lookups_checked, got.eviction_total, want.eviction_total));
    lookups_checked++;
  endtask

  // Access driver: the model is advanced at the edge where the transaction
  // is accepted.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        predict_access(in_data);
        accesses_sent++;
        if (in_data.opcode == OP_NONE) ignored_sent++;
      end
      if (!in_valid || in_ready_o) begin
        if (pending_accesses.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_accesses.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) check_lookup(out_data_o);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SET_BITS:   geo_set_bits   = val;
      CFG_WAYS:       geo_ways       = val;
      CFG_BLOCK_BITS: geo_block_bits = val[2:0];
      default: ;
    endcase
  endtask

  // Holds off until every queued access is taken and every lookup result has
  // arrived, then lets trailing ignored accesses settle. The queues are looked
  // at on the falling edge, after the driver and monitor have updated them.
  task automatic wait_quiet();
    while (pending_accesses.size() != 0 || in_valid || expected_lookups.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic in_t make_access(input logic [1:0] op, input logic [31:0] addr,
                                      input logic [3:0] size);
    in_t a;
    a.opcode      = op;
    a.address     = addr;
    a.access_size = size;
    return a;
  endfunction

  // Hot addresses are spread by power-of-two strides so that many of them
  // share a set under most geometries; half of them survive a geometry change.
  function automatic void refresh_hot_addrs(input bit all_of_them);
    logic [31:0] region;
    region = $urandom();
    for (int k = 0; k < 12; k++) begin
      if (all_of_them || k % 2 == 0)
        hot_addr[k] = region + ($urandom_range(15) << $urandom_range(12));
    end
  endfunction

  function automatic in_t random_access();
    logic [1:0]  ops [3];
    logic [1:0]  op;
    logic [31:0] addr;
    logic [3:0]  size;
    int unsigned pick;
    ops = '{OP_LOAD, OP_STORE, OP_MODIFY};
    op  = ($urandom_range(99) < 8) ? OP_NONE : ops[$urandom_range(2)];
    pick = $urandom_range(99);
    if (pick < 70)      addr = hot_addr[$urandom_range(11)] + $urandom_range(15);
    else if (pick < 88) addr = $urandom();
    else if (pick < 94) addr = 32'hFFFF_FFF0 + $urandom_range(15);
    else                addr = $urandom_range(15);
    size = ($urandom_range(99) < 80) ? 4'($urandom_range(8, 1)) : 4'($urandom_range(15));
    return make_access(op, addr, size);
  endfunction

  initial begin
    int unsigned geo_sb [GEOMS];
    int unsigned geo_w  [GEOMS];
    int unsigned geo_bb [GEOMS];
    int unsigned idle_tbl  [4];
    int unsigned stall_tbl [4];
    geo_sb    = '{0, 8, 15, 2, 3, 1, 5, 9};
    geo_w     = '{1, 8, 15, 0, 4, 2, 8, 3};
    geo_bb    = '{0, 6, 7, 2, 3, 5, 1, 0};
    idle_tbl  = '{0, 65, 0, 36};
    stall_tbl = '{0, 0, 65, 36};

    clear_cache_model();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed accesses under the reset geometry: 16 sets, one way, 16-byte
    // blocks. Covers hit after miss, conflict eviction, block crossing, size
    // zero and oversize, the ignored opcode and wrap past the top of memory.
    pending_accesses.push_back(make_access(OP_LOAD,   32'h0000_0000, 4'd1));
    pending_accesses.push_back(make_access(OP_LOAD,   32'h0000_0004, 4'd4));
    pending_accesses.push_back(make_access(OP_STORE,  32'h0000_0100, 4'd8));
    pending_accesses.push_back(make_access(OP_MODIFY, 32'h0000_0000, 4'd2));
    pending_accesses.push_back(make_access(OP_NONE,   32'h0000_0100, 4'd8));
    pending_accesses.push_back(make_access(OP_LOAD,   32'h0000_001E, 4'd8));
    pending_accesses.push_back(make_access(OP_LOAD,   32'h0000_0030, 4'd0));
    pending_accesses.push_back(make_access(OP_STORE,  32'h0000_0030, 4'd15));
    pending_accesses.push_back(make_access(OP_MODIFY, 32'h0000_003C, 4'd12));
    pending_accesses.push_back(make_access(OP_LOAD,   32'hFFFF_FFFF, 4'd8));
    pending_accesses.push_back(make_access(OP_STORE,  32'hFFFF_FFF0, 4'd8));
    pending_accesses.push_back(make_access(OP_LOAD,   32'h8000_0000, 4'd1));
    pending_accesses.push_back(make_access(OP_LOAD,   32'h7FFF_FFFF, 4'd2));
    pending_accesses.push_back(make_access(OP_MODIFY, 32'hAAAA_AAAA, 4'd8));
    pending_accesses.push_back(make_access(OP_LOAD,   32'h5555_5555, 4'd1));
    pending_accesses.push_back(make_access(OP_NONE,   32'hFFFF_FFFF, 4'd15));
    pending_accesses.push_back(make_access(OP_STORE,  32'h0000_0000, 4'd8));
    wait_quiet();

    refresh_hot_addrs(1'b1);
    for (int g = 0; g < GEOMS; g++) begin
      write_reg(CFG_SET_BITS,   CFG_DATA_W'(geo_sb[g]));
      write_reg(CFG_WAYS,       CFG_DATA_W'(geo_w[g]));
      write_reg(CFG_BLOCK_BITS, CFG_DATA_W'(geo_bb[g]));
      sender_idle_pct = idle_tbl[g % 4];
      recv_stall_pct  = stall_tbl[g % 4];
      refresh_hot_addrs(1'b0);
      // A full-size modify; with byte blocks it yields the most lookups.
      pending_accesses.push_back(make_access(OP_MODIFY, hot_addr[0] + 32'd4, 4'd8));
      for (int n = 0; n < RAND_PER_GEOM; n++) pending_accesses.push_back(random_access());
      wait_quiet();
    end

    if (expected_lookups.size() != 0)
      report_error($sformatf("%0d lookup results never arrived", expected_lookups.size()));
    $display("Covered %0d accesses (%0d ignored) over %0d geometries, %0d lookups checked.",
             accesses_sent, ignored_sent, GEOMS + 1, lookups_checked);
    $display("Final totals: %0d hits, %0d misses, %0d evictions.",
             hit_cnt, miss_cnt, evict_cnt);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/salc_pkg.sv
rtl/salc_mem.sv
rtl/salc_victim.sv
rtl/set_assoc_lru_cache_sim.sv
rtl/salc_checker.sv
tb/tb.sv
